// ===== rtl/bwft_pkg.sv =====
// ----------------------------------------------------------------------------
// bwft_pkg
// Shared widths, status codes and CORDIC constants for the balloon wind
// finder.
// ----------------------------------------------------------------------------
package bwft_pkg;

    localparam int TIME_W   = 18;
    localparam int RANGE_W  = 18;
    localparam int ELEV_W   = 15;
    localparam int AZIM_W   = 16;
    localparam int HGT_W    = 19;
    localparam int SPEED_W  = 16;
    localparam int DIR_W    = 16;
    localparam int TSEC_W   = 17;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FIRST = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DTBAD = 2'd2;

    // multiplier operand and signed product widths
    localparam int MUL_AW = 41;
    localparam int MUL_BW = 33;
    localparam int MUL_PW = 74;

    // CORDIC start gain 0.60725 in Q30
    localparam logic signed [43:0] CORDIC_GAIN = 44'sd652032874;

    typedef logic [31:0] bang_t;

    function automatic bang_t atan_entry(input logic [4:0] idx);
        bang_t r;
        case (idx)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2FA;
            5'd15:   r = 32'h0000517D;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A30;
            5'd19:   r = 32'h00000518;
            5'd20:   r = 32'h0000028C;
            5'd21:   r = 32'h00000146;
            5'd22:   r = 32'h000000A3;
            5'd23:   r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    // saturate a product-sized value to 19-bit signed
    function automatic logic signed [18:0] clamp19(input logic signed [MUL_PW-1:0] v);
        logic signed [18:0] r;
        if (v > 74'sd262143)
            r = 19'sd262143;
        else if (v < -74'sd262144)
            r = -19'sd262144;
        else
            r = v[18:0];
        return r;
    endfunction

endpackage

// ===== rtl/bwft_if.sv =====
// ----------------------------------------------------------------------------
// bwft_if
// Valid/ready channels for tracking fixes and wind results.
// ----------------------------------------------------------------------------
interface bwft_fix_if;
    import bwft_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     start_of_sounding;
    logic [TIME_W-1:0]        time_hhmmss;
    logic [RANGE_W-1:0]       range_m;
    logic signed [ELEV_W-1:0] elevation_cdeg;
    logic [AZIM_W-1:0]        azimuth_cdeg;

    modport source (output valid, start_of_sounding, time_hhmmss, range_m,
                    elevation_cdeg, azimuth_cdeg, input ready);
    modport sink   (input valid, start_of_sounding, time_hhmmss, range_m,
                    elevation_cdeg, azimuth_cdeg, output ready);
endinterface

interface bwft_wind_if;
    import bwft_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [HGT_W-1:0] height_m;
    logic [SPEED_W-1:0]      wind_speed_cms;
    logic [DIR_W-1:0]        wind_dir_cdeg;
    logic [TSEC_W-1:0]       time_s;
    logic [STATUS_W-1:0]     status;

    modport source (output valid, height_m, wind_speed_cms, wind_dir_cdeg, time_s,
                    status, input ready);
    modport sink   (input valid, height_m, wind_speed_cms, wind_dir_cdeg, time_s,
                    status, output ready);
endinterface

// ===== rtl/balloon_wind_from_tracking_unit.sv =====
// ----------------------------------------------------------------------------
// balloon_wind_from_tracking_unit
// Height, position and wind from successive balloon tracking fixes.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  fix      in   start_of_sounding, time_hhmmss, range_m, elevation_cdeg,
//                azimuth_cdeg
//  wind     out  height_m, wind_speed_cms, wind_dir_cdeg, time_s, status
//
//  One fix at a time. A fix runs two angle divisions, two CORDIC rotations
//  and four multiplies when it gives no wind, and with wind four more
//  multiplies, the square root, the speed divider and a CORDIC vectoring
//  pass. It uses the shared serial multiplier (one operand bit per cycle)
//  and the bit-serial angle divider. Time of day is converted alongside by
//  repeated subtraction. Reset clears the previous fix. The result register
//  frees the input side: the next fix is taken while a result waits; a
//  stalled result holds the unit only at its final write.
// ----------------------------------------------------------------------------
module balloon_wind_from_tracking_unit #(
    parameter int CORDIC_STEPS = 18
) (
    input  logic               clk,
    input  logic               rst_n,
    bwft_fix_if.sink           fix,
    bwft_wind_if.source        wind
);
    import bwft_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_BANG   = 4'd1;
    localparam logic [3:0] S_ROT    = 4'd2;
    localparam logic [3:0] S_MUL_LD = 4'd3;
    localparam logic [3:0] S_MUL    = 4'd4;
    localparam logic [3:0] S_MUL_WB = 4'd5;
    localparam logic [3:0] S_SQRT   = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_VEC    = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    localparam logic [2:0] M_HGT = 3'd0;
    localparam logic [2:0] M_HQ  = 3'd1;
    localparam logic [2:0] M_X   = 3'd2;
    localparam logic [2:0] M_Y   = 3'd3;
    localparam logic [2:0] M_DXX = 3'd4;
    localparam logic [2:0] M_DYY = 3'd5;
    localparam logic [2:0] M_CM  = 3'd6;
    localparam logic [2:0] M_DIR = 3'd7;

    localparam logic [1:0] TP_HR   = 2'd0;
    localparam logic [1:0] TP_MIN  = 2'd1;
    localparam logic [1:0] TP_DONE = 2'd2;

    localparam logic [5:0] BANG_LAST = 6'd47;
    localparam logic [5:0] MUL_LAST  = 6'(MUL_BW - 1);
    localparam logic [5:0] SQRT_LAST = 6'd26;
    localparam logic [5:0] DIV_LAST  = 6'd27;
    localparam logic [5:0] CORD_LAST = 6'(CORDIC_STEPS - 1);

    // control
    logic [3:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       pass_reg, pass_next;
    logic [2:0] mstep_reg, mstep_next;
    logic       vec_reg, vec_next;
    logic [1:0] tph_reg, tph_next;
    logic       out_valid_reg, out_valid_next;
    logic       have_prev_reg, have_prev_next;
    logic signed [18:0] prev_x_reg, prev_x_next;
    logic signed [18:0] prev_y_reg, prev_y_next;
    logic [16:0] prev_t_reg, prev_t_next;

    // payload
    logic        start_reg, start_next;
    logic [17:0] rng_reg, rng_next;
    logic [15:0] az_c_reg, az_c_next;
    logic [17:0] t_rem_reg, t_rem_next;
    logic [16:0] tsec_reg, tsec_next;
    logic [47:0] bg_n_reg, bg_n_next;
    logic [16:0] bg_rem_reg, bg_rem_next;
    logic [31:0] bg_q_reg, bg_q_next;
    logic signed [43:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [33:0] cz_reg, cz_next;
    logic [1:0]  quad_reg, quad_next;
    logic signed [32:0] ce_reg, ce_next, se_reg, se_next;
    logic signed [32:0] ca_reg, ca_next, sa_reg, sa_next;
    logic [72:0] acc_reg, acc_next, ash_reg, ash_next;
    logic [32:0] bsh_reg, bsh_next;
    logic        neg_reg, neg_next;
    logic signed [18:0] hgt_reg, hgt_next, x_reg, x_next, y_reg, y_next;
    logic signed [32:0] hq_reg, hq_next;
    logic signed [19:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [39:0] sq1_reg, sq1_next, d2_reg, d2_next;
    logic [53:0] sv_reg, sv_next, sres_reg, sres_next, sbit_reg, sbit_next;
    logic [27:0] dnum_reg, dnum_next, dq_reg, dq_next;
    logic [16:0] drem_reg, drem_next;
    logic [1:0]  status_reg, status_next;
    logic [15:0] speed_reg, speed_next, dir_reg, dir_next;
    logic signed [18:0] o_hgt_reg, o_hgt_next;
    logic [15:0] o_speed_reg, o_speed_next, o_dir_reg, o_dir_next;
    logic [16:0] o_tsec_reg, o_tsec_next;
    logic [1:0]  o_status_reg, o_status_next;

    // combinational helpers
    logic        accept;
    logic [15:0] el_c_in, az_c_in;
    logic [16:0] bg_r2;
    logic        bg_ge;
    logic [31:0] bg_q_nx, rot_sum, rot_rr;
    logic [1:0]  rot_q;
    logic [4:0]  iter;
    logic signed [43:0] xs, ys, cx_nx, cy_nx;
    logic signed [33:0] cz_nx, at_ext;
    logic        dpos;
    logic signed [32:0] mx, my, map_c, map_s;
    logic signed [40:0] ld_a;
    logic signed [32:0] ld_b;
    logic signed [MUL_PW-1:0] prod, r30, r18, r42, r32;
    logic signed [18:0] y_new;
    logic signed [19:0] dx_new, dy_new;
    logic signed [17:0] dt;
    logic        dt_bad;
    logic [53:0] sq_sum, sres_nx;
    logic        sq_ge;
    logic [17:0] dv_r2, dv_den;
    logic        dv_ge;
    logic [27:0] dq_nx;
    logic signed [43:0] vx0, vy0;

    assign accept   = fix.valid && fix.ready;
    assign fix.ready = (state_reg == S_IDLE);

    assign el_c_in = fix.elevation_cdeg[14]
                   ? 16'(17'd36000 + {{2{fix.elevation_cdeg[14]}}, fix.elevation_cdeg})
                   : {1'b0, fix.elevation_cdeg};
    assign az_c_in = (fix.azimuth_cdeg >= 16'd36000) ? fix.azimuth_cdeg - 16'd36000
                                                     : fix.azimuth_cdeg;

    // angle divider: one quotient bit per cycle
    assign bg_r2   = {bg_rem_reg[15:0], bg_n_reg[47]};
    assign bg_ge   = (bg_r2 >= 17'd36000);
    assign bg_q_nx = {bg_q_reg[30:0], bg_ge};
    assign rot_sum = bg_q_nx + 32'h2000_0000;
    assign rot_q   = rot_sum[31:30];
    assign rot_rr  = bg_q_nx - {rot_q, 30'd0};

    // shared CORDIC step
    assign iter   = cnt_reg[4:0];
    assign xs     = cx_reg >>> iter;
    assign ys     = cy_reg >>> iter;
    assign at_ext = $signed({2'b00, atan_entry(iter)});
    assign dpos   = vec_reg ? cy_reg[43] : ~cz_reg[33];
    assign cx_nx  = dpos ? cx_reg - ys : cx_reg + ys;
    assign cy_nx  = dpos ? cy_reg + xs : cy_reg - xs;
    assign cz_nx  = dpos ? cz_reg - at_ext : cz_reg + at_ext;
    assign mx     = cx_nx[32:0];
    assign my     = cy_nx[32:0];

    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                map_c = mx;
                map_s = my;
            end
            2'd1:
            begin
                map_c = -my;
                map_s = mx;
            end
            2'd2:
            begin
                map_c = -mx;
                map_s = -my;
            end
            default:
            begin
                map_c = my;
                map_s = -mx;
            end
        endcase
    end

    // multiplier operand select
    always_comb
    begin
        case (mstep_reg)
            M_HGT:
            begin
                ld_a = $signed({23'd0, rng_reg});
                ld_b = se_reg;
            end
            M_HQ:
            begin
                ld_a = $signed({23'd0, rng_reg});
                ld_b = ce_reg;
            end
            M_X:
            begin
                ld_a = 41'(hq_reg);
                ld_b = sa_reg;
            end
            M_Y:
            begin
                ld_a = 41'(hq_reg);
                ld_b = ca_reg;
            end
            M_DXX:
            begin
                ld_a = 41'(dx_reg);
                ld_b = 33'(dx_reg);
            end
            M_DYY:
            begin
                ld_a = 41'(dy_reg);
                ld_b = 33'(dy_reg);
            end
            M_CM:
            begin
                ld_a = $signed({1'b0, d2_reg});
                ld_b = 33'sd10000;
            end
            default:
            begin
                ld_a = $signed({9'd0, cz_reg[31:0]});
                ld_b = 33'sd36000;
            end
        endcase
    end

    assign prod = neg_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});
    assign r30  = (prod + (74'sd1 <<< 29)) >>> 30;
    assign r18  = (prod + (74'sd1 <<< 17)) >>> 18;
    assign r42  = (prod + (74'sd1 <<< 41)) >>> 42;
    assign r32  = (prod + (74'sd1 <<< 31)) >>> 32;

    assign y_new  = clamp19(r42);
    assign dx_new = 20'(x_reg) - 20'(prev_x_reg);
    assign dy_new = 20'(y_new) - 20'(prev_y_reg);
    assign dt     = $signed({1'b0, tsec_reg}) - $signed({1'b0, prev_t_reg});
    assign dt_bad = dt[17] || (dt == 18'sd0);

    // square root, one result bit per cycle
    assign sq_sum  = sres_reg + sbit_reg;
    assign sq_ge   = (sv_reg >= sq_sum);
    assign sres_nx = sq_ge ? (sres_reg >> 1) + sbit_reg : (sres_reg >> 1);

    // speed divider, one quotient bit per cycle
    assign dv_den = {1'b0, dt[16:0]};
    assign dv_r2  = {drem_reg, dnum_reg[27]};
    assign dv_ge  = (dv_r2 >= dv_den);
    assign dq_nx  = {dq_reg[26:0], dv_ge};

    assign vx0 = 44'(dy_reg) <<< 20;
    assign vy0 = 44'(dx_reg) <<< 20;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg + 6'd1;
        pass_next      = pass_reg;
        mstep_next     = mstep_reg;
        vec_next       = vec_reg;
        tph_next       = tph_reg;
        out_valid_next = out_valid_reg && !wind.ready;
        have_prev_next = have_prev_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        prev_t_next    = prev_t_reg;
        start_next     = start_reg;
        rng_next       = rng_reg;
        az_c_next      = az_c_reg;
        t_rem_next     = t_rem_reg;
        tsec_next      = tsec_reg;
        bg_n_next      = bg_n_reg;
        bg_rem_next    = bg_rem_reg;
        bg_q_next      = bg_q_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        quad_next      = quad_reg;
        ce_next        = ce_reg;
        se_next        = se_reg;
        ca_next        = ca_reg;
        sa_next        = sa_reg;
        acc_next       = acc_reg;
        ash_next       = ash_reg;
        bsh_next       = bsh_reg;
        neg_next       = neg_reg;
        hgt_next       = hgt_reg;
        hq_next        = hq_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        sq1_next       = sq1_reg;
        d2_next        = d2_reg;
        sv_next        = sv_reg;
        sres_next      = sres_reg;
        sbit_next      = sbit_reg;
        dnum_next      = dnum_reg;
        drem_next      = drem_reg;
        dq_next        = dq_reg;
        status_next    = status_reg;
        speed_next     = speed_reg;
        dir_next       = dir_reg;
        o_hgt_next     = o_hgt_reg;
        o_speed_next   = o_speed_reg;
        o_dir_next     = o_dir_reg;
        o_tsec_next    = o_tsec_reg;
        o_status_next  = o_status_reg;

        // time of day: strip hours, then minutes
        case (tph_reg)
            TP_HR:
            begin
                if (t_rem_reg >= 18'd10000)
                begin
                    t_rem_next = t_rem_reg - 18'd10000;
                    tsec_next  = tsec_reg + 17'd3600;
                end
                else
                begin
                    tph_next = TP_MIN;
                end
            end
            TP_MIN:
            begin
                if (t_rem_reg >= 18'd100)
                begin
                    t_rem_next = t_rem_reg - 18'd100;
                    tsec_next  = tsec_reg + 17'd60;
                end
                else
                begin
                    tsec_next = tsec_reg + {10'd0, t_rem_reg[6:0]};
                    tph_next  = TP_DONE;
                end
            end
            default:
            begin
                tph_next = tph_reg;
            end
        endcase

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    start_next  = fix.start_of_sounding;
                    rng_next    = fix.range_m;
                    az_c_next   = az_c_in;
                    t_rem_next  = fix.time_hhmmss;
                    tsec_next   = '0;
                    tph_next    = TP_HR;
                    bg_n_next   = {el_c_in, 32'd18000};
                    bg_rem_next = '0;
                    pass_next   = 1'b0;
                    cnt_next    = '0;
                    state_next  = S_BANG;
                end
            end
            S_BANG:
            begin
                bg_rem_next = bg_ge ? bg_r2 - 17'd36000 : bg_r2;
                bg_q_next   = bg_q_nx;
                bg_n_next   = {bg_n_reg[46:0], 1'b0};
                if (cnt_reg == BANG_LAST)
                begin
                    cx_next    = CORDIC_GAIN;
                    cy_next    = '0;
                    cz_next    = {{2{rot_rr[31]}}, rot_rr};
                    quad_next  = rot_q;
                    vec_next   = 1'b0;
                    cnt_next   = '0;
                    state_next = S_ROT;
                end
            end
            S_ROT:
            begin
                cx_next = cx_nx;
                cy_next = cy_nx;
                cz_next = cz_nx;
                if (cnt_reg == CORD_LAST)
                begin
                    cnt_next = '0;
                    if (!pass_reg)
                    begin
                        ce_next     = map_c;
                        se_next     = map_s;
                        bg_n_next   = {az_c_reg, 32'd18000};
                        bg_rem_next = '0;
                        pass_next   = 1'b1;
                        state_next  = S_BANG;
                    end
                    else
                    begin
                        ca_next    = map_c;
                        sa_next    = map_s;
                        mstep_next = M_HGT;
                        state_next = S_MUL_LD;
                    end
                end
            end
            S_MUL_LD:
            begin
                acc_next   = '0;
                ash_next   = {32'd0, ld_a[40] ? 41'(-ld_a) : 41'(ld_a)};
                bsh_next   = ld_b[32] ? 33'(-ld_b) : 33'(ld_b);
                neg_next   = ld_a[40] ^ ld_b[32];
                cnt_next   = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (bsh_reg[0])
                    acc_next = acc_reg + ash_reg;
                ash_next = {ash_reg[71:0], 1'b0};
                bsh_next = {1'b0, bsh_reg[32:1]};
                if (cnt_reg == MUL_LAST)
                    state_next = S_MUL_WB;
            end
            S_MUL_WB:
            begin
                mstep_next = mstep_reg + 3'd1;
                state_next = S_MUL_LD;
                case (mstep_reg)
                    M_HGT: hgt_next = clamp19(r30);
                    M_HQ:  hq_next  = r18[32:0];
                    M_X:   x_next   = clamp19(r42);
                    M_Y:
                    begin
                        y_next     = y_new;
                        dx_next    = dx_new;
                        dy_next    = dy_new;
                        speed_next = '0;
                        dir_next   = '0;
                        if (start_reg || !have_prev_reg)
                        begin
                            status_next = ST_FIRST;
                            state_next  = S_DONE;
                        end
                        else if (dt_bad)
                        begin
                            status_next = ST_DTBAD;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            status_next = ST_OK;
                            if (dx_new == 20'sd0 && dy_new == 20'sd0)
                                state_next = S_DONE;
                        end
                    end
                    M_DXX: sq1_next = prod[39:0];
                    M_DYY: d2_next  = sq1_reg + prod[39:0];
                    M_CM:
                    begin
                        sv_next    = prod[53:0];
                        sres_next  = '0;
                        sbit_next  = 54'd1 << 52;
                        cnt_next   = '0;
                        state_next = S_SQRT;
                    end
                    default:
                    begin
                        dir_next   = (r32[16:0] >= 17'd36000) ? 16'd0 : r32[15:0];
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SQRT:
            begin
                if (sq_ge)
                    sv_next = sv_reg - sq_sum;
                sres_next = sres_nx;
                sbit_next = sbit_reg >> 2;
                if (cnt_reg == SQRT_LAST)
                begin
                    dnum_next  = {1'b0, sres_nx[26:0]} + {12'd0, dt[16:1]};
                    drem_next  = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                drem_next = 17'(dv_ge ? dv_r2 - dv_den : dv_r2);
                dq_next   = dq_nx;
                dnum_next = {dnum_reg[26:0], 1'b0};
                if (cnt_reg == DIV_LAST)
                begin
                    speed_next = (|dq_nx[27:16]) ? 16'hFFFF : dq_nx[15:0];
                    // fold the vector into the right half plane first
                    if (dy_reg[19])
                    begin
                        cx_next = -vx0;
                        cy_next = -vy0;
                        cz_next = 34'h0_8000_0000;
                    end
                    else
                    begin
                        cx_next = vx0;
                        cy_next = vy0;
                        cz_next = '0;
                    end
                    vec_next   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_VEC;
                end
            end
            S_VEC:
            begin
                cx_next = cx_nx;
                cy_next = cy_nx;
                cz_next = cz_nx;
                if (cnt_reg == CORD_LAST)
                begin
                    mstep_next = M_DIR;
                    state_next = S_MUL_LD;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || wind.ready)
                begin
                    out_valid_next = 1'b1;
                    o_hgt_next     = hgt_reg;
                    o_speed_next   = speed_reg;
                    o_dir_next     = dir_reg;
                    o_tsec_next    = tsec_reg;
                    o_status_next  = status_reg;
                    prev_x_next    = x_reg;
                    prev_y_next    = y_reg;
                    prev_t_next    = tsec_reg;
                    have_prev_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pass_reg      <= 1'b0;
            mstep_reg     <= M_HGT;
            vec_reg       <= 1'b0;
            tph_reg       <= TP_DONE;
            out_valid_reg <= 1'b0;
            have_prev_reg <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_t_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pass_reg      <= pass_next;
            mstep_reg     <= mstep_next;
            vec_reg       <= vec_next;
            tph_reg       <= tph_next;
            out_valid_reg <= out_valid_next;
            have_prev_reg <= have_prev_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            prev_t_reg    <= prev_t_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg    <= start_next;
        rng_reg      <= rng_next;
        az_c_reg     <= az_c_next;
        t_rem_reg    <= t_rem_next;
        tsec_reg     <= tsec_next;
        bg_n_reg     <= bg_n_next;
        bg_rem_reg   <= bg_rem_next;
        bg_q_reg     <= bg_q_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        cz_reg       <= cz_next;
        quad_reg     <= quad_next;
        ce_reg       <= ce_next;
        se_reg       <= se_next;
        ca_reg       <= ca_next;
        sa_reg       <= sa_next;
        acc_reg      <= acc_next;
        ash_reg      <= ash_next;
        bsh_reg      <= bsh_next;
        neg_reg      <= neg_next;
        hgt_reg      <= hgt_next;
        hq_reg       <= hq_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        sq1_reg      <= sq1_next;
        d2_reg       <= d2_next;
        sv_reg       <= sv_next;
        sres_reg     <= sres_next;
        sbit_reg     <= sbit_next;
        dnum_reg     <= dnum_next;
        drem_reg     <= drem_next;
        dq_reg       <= dq_next;
        status_reg   <= status_next;
        speed_reg    <= speed_next;
        dir_reg      <= dir_next;
        o_hgt_reg    <= o_hgt_next;
        o_speed_reg  <= o_speed_next;
        o_dir_reg    <= o_dir_next;
        o_tsec_reg   <= o_tsec_next;
        o_status_reg <= o_status_next;
    end

    assign wind.valid          = out_valid_reg;
    assign wind.height_m       = o_hgt_reg;
    assign wind.wind_speed_cms = o_speed_reg;
    assign wind.wind_dir_cdeg  = o_dir_reg;
    assign wind.time_s         = o_tsec_reg;
    assign wind.status         = o_status_reg;

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !fix.ready)
        else $error("fix channel ready while a transaction is in flight");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_BANG)
        else $error("accepted fix did not start the angle divider");

    a_time_ready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |-> tph_reg == TP_DONE)
        else $error("time conversion unfinished at result write");

    a_no_wind_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        wind.valid && wind.status != ST_OK |->
            wind.wind_speed_cms == 16'd0 && wind.wind_dir_cdeg == 16'd0)
        else $error("flagged result carries wind");

    a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
        wind.valid |-> wind.wind_dir_cdeg < 16'd36000)
        else $error("direction out of range");

endmodule

// ===== sim/tb_balloon_wind_from_tracking_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_balloon_wind_from_tracking_unit
// Drives tracking fixes with random gaps and checks each wind result against
// a fixed-point prediction of height, time, status, speed and bearing.
// ----------------------------------------------------------------------------
module tb_balloon_wind_from_tracking_unit;
    import bwft_pkg::*;

    typedef struct packed {
        logic signed [HGT_W-1:0] height_m;
        logic [SPEED_W-1:0]      wind_speed_cms;
        logic [DIR_W-1:0]        wind_dir_cdeg;
        logic [TSEC_W-1:0]       time_s;
        logic [STATUS_W-1:0]     status;
    } wind_t;

    localparam int STEPS = 18;

    logic clk;
    logic rst_n;
    bit   failed = 1'b0;
    int   cycles = 0;

    bwft_fix_if  fix ();
    bwft_wind_if wind ();

    balloon_wind_from_tracking_unit #(.CORDIC_STEPS(STEPS)) DUT (
        .clk(clk), .rst_n(rst_n), .fix(fix.sink), .wind(wind.source)
    );

    function automatic logic [31:0] atan_val(int i);
        logic [31:0] t [24] = '{
            32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
            32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
            32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
            32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
        return t[i];
    endfunction

    // rounding shift; >>> on signed longint floors, so half is added first
    function automatic longint rshift_round(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint sat19(longint v);
        if (v > 262143) return 262143;
        if (v < -262144) return -262144;
        return v;
    endfunction

    function automatic logic [31:0] cdeg_to_angle(longint unsigned c);
        return 32'(((c << 32) + 18000) / 36000);
    endfunction

    task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
        logic [1:0]  q;
        logic [31:0] rr;
        longint z, x, y, nx, ny;
        q  = 2'((ang + 32'h20000000) >> 30);
        rr = ang - (32'(q) << 30);
        z  = longint'($signed(rr));
        x  = 652032874;
        y  = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_val(i);
            end
            else
            begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += atan_val(i);
            end
            x = nx; y = ny;
        end
        case (q)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    function automatic logic [15:0] bearing(longint dx, longint dy);
        longint x, y, nx, ny;
        logic [31:0] z;
        logic [63:0] cd;
        x = dy * 1048576; y = dx * 1048576; z = 0;
        if (x < 0)
        begin
            x = -x; y = -y; z = 32'h80000000;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += atan_val(i);
            end
            else
            begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_val(i);
            end
            x = nx; y = ny;
        end
        cd = (64'(z) * 36000 + 64'h80000000) >> 32;
        return (cd >= 36000) ? 16'd0 : 16'(cd);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0; b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b; r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    class wind_scoreboard;
        wind_t  pending[$];
        longint last_x, last_y, last_t;
        bit     have_last;

        task note_fix(bit sos, logic [17:0] hms, logic [17:0] rng,
                      logic [14:0] elv, logic [15:0] azm);
            wind_t  w;
            longint el, az, ts, ce, se, ca, sa, hq, x, y, dx, dy, dt;
            longint unsigned sp, cm;
            el = longint'($signed(elv));
            if (el < 0) el += 36000;
            az = azm % 36000;
            ts = (hms / 10000) * 3600 + ((hms / 100) % 100) * 60 + (hms % 100);
            rotate(cdeg_to_angle(el), ce, se);
            rotate(cdeg_to_angle(az), ca, sa);
            w = '0;
            w.height_m = HGT_W'(sat19(rshift_round(longint'(rng) * se, 30)));
            hq = rshift_round(longint'(rng) * ce, 18);
            x = sat19(rshift_round(hq * sa, 42));
            y = sat19(rshift_round(hq * ca, 42));
            w.time_s = TSEC_W'(ts);
            if (sos || !have_last)
                w.status = ST_FIRST;
            else
            begin
                dt = ts - last_t;
                if (dt <= 0)
                    w.status = ST_DTBAD;
                else
                begin
                    w.status = ST_OK;
                    dx = x - last_x; dy = y - last_y;
                    if (dx != 0 || dy != 0)
                    begin
                        cm = int_sqrt(longint'(dx * dx + dy * dy) * 10000);
                        sp = (cm + dt / 2) / dt;
                        w.wind_speed_cms = (sp > 65535) ? 16'hFFFF : 16'(sp);
                        w.wind_dir_cdeg = bearing(dx, dy);
                    end
                end
            end
            last_x = x; last_y = y; last_t = ts & 17'h1FFFF; have_last = 1;
            pending.push_back(w);
        endtask

        function bit check_wind(wind_t got);
            wind_t e;
            if (pending.size() == 0)
            begin
                $display("%0t unexpected result %p", $time, got);
                return 0;
            end
            e = pending.pop_front();
            if (got !== e)
            begin
                $display("%0t mismatch expected %p actual %p", $time, e, got);
                return 0;
            end
            return 1;
        endfunction
    endclass

    wind_scoreboard sb = new();

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // result sink with random stalls
    initial
    begin
        int g;
        wind.ready = 0;
        @(posedge rst_n);
        forever
        begin
            g = pick_gap();
            repeat (g) @(posedge clk) wind.ready <= 0;
            @(posedge clk) wind.ready <= 1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && wind.valid && wind.ready)
            if (!sb.check_wind({wind.height_m, wind.wind_speed_cms, wind.wind_dir_cdeg,
                                wind.time_s, wind.status}))
                failed = 1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 6000000)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_fix(bit sos, logic [17:0] hms, logic [17:0] rng,
                            logic [14:0] elv, logic [15:0] azm);
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            @(posedge clk) fix.valid <= 0;
            repeat (g - 1) @(posedge clk);
        end
        @(posedge clk);
        fix.valid <= 1;
        fix.start_of_sounding <= sos;
        fix.time_hhmmss <= hms;
        fix.range_m <= rng;
        fix.elevation_cdeg <= elv;
        fix.azimuth_cdeg <= azm;
        do @(posedge clk); while (!fix.ready);
        sb.note_fix(sos, hms, rng, elv, azm);
        fix.valid <= 0;
    endtask

    function automatic logic [17:0] hms_of(int s);
        return 18'((s / 3600) * 10000 + ((s / 60) % 60) * 100 + s % 60);
    endfunction

    initial
    begin
        int t, n;
        rst_n = 0;
        fix.valid = 0; fix.start_of_sounding = 0; fix.time_hhmmss = 0;
        fix.range_m = 0; fix.elevation_cdeg = 0; fix.azimuth_cdeg = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1;

        // directed: extremes, no-prev, bad step, no motion, odd angles and digits
        send_fix(0, 18'd0, 18'd0, 15'sd0, 16'd0);
        send_fix(0, 18'd1, 18'h3FFFF, 15'sd9000, 16'd0);
        send_fix(0, 18'd2, 18'h3FFFF, 15'sd0, 16'd9000);
        send_fix(0, 18'd2, 18'd1000, 15'sd0, 16'd0);
        send_fix(0, 18'd1, 18'd1000, 15'sd0, 16'd0);
        send_fix(0, 18'd5, 18'd1000, 15'sd0, 16'd0);
        send_fix(0, 18'd6, 18'd1000, 15'sd0, 16'd1);
        send_fix(1, 18'd235959, 18'd5000, -15'sd1000, 16'd35999);
        send_fix(0, 18'h3FFFF, 18'd5000, 15'h7FFF, 16'hFFFF);
        send_fix(1, 18'd100, 18'h3FFFF, 15'h4000, 16'd18000);
        send_fix(0, 18'd101, 18'd0, 15'h3FFF, 16'd27000);
        send_fix(0, 18'd999, 18'd200000, 15'sd4500, 16'h8000);
        send_fix(0, 18'd1000, 18'd200001, 15'sd4500, 16'd36000);
        send_fix(0, 18'd1001, 18'd12345, 15'sd3000, 16'd4500);

        // random soundings, mostly increasing steps of one to five seconds
        t = 0;
        for (int i = 0; i < 1300; i++)
        begin
            n = $urandom_range(0, 99);
            if (n < 4) t = $urandom_range(0, 86399);
            else if (n < 8) t = t - $urandom_range(0, 3);
            else t = t + $urandom_range(1, 5);
            if (t < 0) t = 0;
            if (t > 86399) t = 86399;
            if ($urandom_range(0, 19) == 0)
                send_fix($urandom_range(0, 9) == 0, 18'($urandom),
                         18'($urandom), 15'($urandom), 16'($urandom));
            else
                send_fix($urandom_range(0, 49) == 0, hms_of(t),
                         18'($urandom_range(0, ($urandom_range(0, 3) == 0) ? 262143 : 60000)),
                         15'($signed($urandom_range(0, 10000)) - 1000),
                         16'($urandom_range(0, 35999)));
        end

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (700) @(posedge clk);
        if (!failed)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
